// ===== rtl/core/decimal_fixed_point_alu_core_assert.svh =====
// assertion macros for the scaled decimal arithmetic core
// needs clk_i and rst_ni in the scope of the module that uses them
`ifndef DECIMAL_FIXED_POINT_ALU_CORE_ASSERT_SVH
`define DECIMAL_FIXED_POINT_ALU_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define DFPA_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define DFPA_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DFPA_ASSERT_IMP(name, ante, cons, msg)
`define DFPA_ASSERT_NXT(name, ante, cons, msg)
`endif
`endif

// ===== rtl/core/dfpa_pkg.sv =====
// shared types and constants of the scaled decimal arithmetic core
// no dependencies
package dfpa_pkg;

  localparam int unsigned DataW       = 64;
  localparam int unsigned CfgW        = 5;
  localparam int unsigned MaxDigits   = 18;
  localparam int unsigned PrecisionRst = 18;
  localparam int unsigned ScaleRst    = 0;
  localparam int unsigned FifoDepth   = 2;
  localparam int unsigned PtrW        = $clog2(FifoDepth);

  typedef enum logic [3:0] {
    CMD_ADD   = 4'd0,
    CMD_SUB   = 4'd1,
    CMD_MUL   = 4'd2,
    CMD_DIV   = 4'd3,
    CMD_MOD   = 4'd4,
    CMD_NEG   = 4'd5,
    CMD_ABS   = 4'd6,
    CMD_FLOOR = 4'd7,
    CMD_CEIL  = 4'd8
  } cmd_e;

  typedef enum logic [3:0] {
    OP_NOP, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_NEG, OP_ABS, OP_FLOOR, OP_CEIL
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_DIV0 = 2'd2
  } status_e;

  typedef enum logic {
    CFG_PRECISION = 1'b0,
    CFG_SCALE     = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [3:0]              cmd;
    logic signed [DataW-1:0] operand_a;
    logic signed [DataW-1:0] operand_b;
  } dfpa_in_t;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    status_e                 status;
  } dfpa_out_t;

  // classified item in sign and magnitude form
  typedef struct packed {
    op_e              op;
    logic             a_neg;
    logic [DataW-1:0] a_mag;
    logic             b_neg;
    logic [DataW-1:0] b_mag;
  } dfpa_item_t;

  // queue occupancy seen by the front
  typedef struct packed {
    logic pend;
    logic full;
  } dfpa_front_stat_t;

endpackage

// ===== rtl/core/dfpa_front.sv =====
// front end: takes input transfers, decodes the command and converts operands
// to sign and magnitude; depends on dfpa_pkg
module dfpa_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  dfpa_pkg::dfpa_in_t   in_data_i,
  output logic                 item_valid_o,
  input  logic                 item_ready_i,
  output dfpa_pkg::dfpa_item_t item_o
);
  import dfpa_pkg::*;

  logic             vld_q;
  dfpa_item_t       item_q, item_d;
  logic [DataW-1:0] a_bits, b_bits;

  assign in_ready_o   = !vld_q || item_ready_i;
  assign item_valid_o = vld_q;
  assign item_o       = item_q;

  always_comb begin
    a_bits = in_data_i.operand_a;
    b_bits = in_data_i.operand_b;
    item_d.a_neg = a_bits[DataW-1];
    item_d.a_mag = a_bits[DataW-1] ? (~a_bits + 64'd1) : a_bits;
    item_d.b_neg = b_bits[DataW-1];
    item_d.b_mag = b_bits[DataW-1] ? (~b_bits + 64'd1) : b_bits;
    case (in_data_i.cmd)
      CMD_ADD:   item_d.op = OP_ADD;
      CMD_SUB:   item_d.op = OP_SUB;
      CMD_MUL:   item_d.op = OP_MUL;
      CMD_DIV:   item_d.op = OP_DIV;
      CMD_MOD:   item_d.op = OP_MOD;
      CMD_NEG:   item_d.op = OP_NEG;
      CMD_ABS:   item_d.op = OP_ABS;
      CMD_FLOOR: item_d.op = OP_FLOOR;
      CMD_CEIL:  item_d.op = OP_CEIL;
      default:   item_d.op = OP_NOP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_d;
    end
  end

endmodule

// ===== rtl/core/dfpa_fifo.sv =====
// short queue of classified items between front and back
// depends on dfpa_pkg
module dfpa_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_valid_i,
  output logic                 push_ready_o,
  input  dfpa_pkg::dfpa_item_t push_data_i,
  output logic                 pop_valid_o,
  input  logic                 pop_ready_i,
  output dfpa_pkg::dfpa_item_t pop_data_o
);
  import dfpa_pkg::*;

  dfpa_item_t      mem_q [FifoDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;
  logic            push, pop;

  assign push_ready_o = cnt_q != (PtrW+1)'(FifoDepth);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrW'(FifoDepth-1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PtrW'(FifoDepth-1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/core/dfpa_back.sv =====
// back end: split multiplier, range checks, pipelined radix-2 divider and
// result rounding into the output register; depends on dfpa_pkg
module dfpa_back #(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [4:0]           precision_i,
  input  logic [4:0]           scale_i,
  input  logic                 item_valid_i,
  output logic                 item_ready_o,
  input  dfpa_pkg::dfpa_item_t item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output dfpa_pkg::dfpa_out_t  out_data_o
);
  import dfpa_pkg::*;

  localparam int unsigned DivSteps = DataW;
  localparam logic [DataW-1:0] WMinMag = 64'd1 << (WORD_BITS - 1);
  localparam logic [DataW-1:0] WMaxMag = WMinMag - 64'd1;

  typedef struct packed {
    dfpa_item_t       item;
    logic [DataW-1:0] pp00;
    logic [DataW-1:0] pp01;
    logic [DataW-1:0] pp10;
    logic [DataW-1:0] pp11;
  } mul_t;

  typedef struct packed {
    dfpa_item_t         item;
    logic [2*DataW-1:0] prod;
  } prod_t;

  // nq holds the dividend and collects the quotient bit by bit
  typedef struct packed {
    op_e              op;
    status_e          st;
    logic             res_neg;
    logic [DataW-1:0] res_mag;
    logic [DataW-1:0] den;
    logic [DataW-1:0] rem;
    logic [DataW-1:0] nq;
  } div_t;

  function automatic logic [DataW-1:0] pow10(input logic [4:0] idx);
    logic [DataW-1:0] r;
    case (idx)
      5'd0:    r = 64'd1;
      5'd1:    r = 64'd10;
      5'd2:    r = 64'd100;
      5'd3:    r = 64'd1000;
      5'd4:    r = 64'd10000;
      5'd5:    r = 64'd100000;
      5'd6:    r = 64'd1000000;
      5'd7:    r = 64'd10000000;
      5'd8:    r = 64'd100000000;
      5'd9:    r = 64'd1000000000;
      5'd10:   r = 64'd10000000000;
      5'd11:   r = 64'd100000000000;
      5'd12:   r = 64'd1000000000000;
      5'd13:   r = 64'd10000000000000;
      5'd14:   r = 64'd100000000000000;
      5'd15:   r = 64'd1000000000000000;
      5'd16:   r = 64'd10000000000000000;
      5'd17:   r = 64'd100000000000000000;
      5'd18:   r = 64'd1000000000000000000;
      5'd19:   r = 64'd10000000000000000000;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic fits(input logic neg, input logic [DataW-1:0] mag);
    return neg ? (mag <= WMinMag) : (mag <= WMaxMag);
  endfunction

  function automatic div_t div_step(input div_t x);
    div_t       r;
    logic [DataW:0] sh, trial;
    sh    = {x.rem, x.nq[DataW-1]};
    trial = sh - {1'b0, x.den};
    r     = x;
    r.nq  = {x.nq[DataW-2:0], ~trial[DataW]};
    r.rem = trial[DataW] ? sh[DataW-1:0] : trial[DataW-1:0];
    return r;
  endfunction

  logic                adv;
  logic                v1_q, v2_q, v3_q, out_valid_q;
  logic [DivSteps-1:0] dv_q;
  mul_t                s1_q, s1_d;
  prod_t               s2_q, s2_d;
  div_t                s3_q, s3_d;
  div_t                dq_q [DivSteps];
  dfpa_out_t           out_q, out_d;

  logic [4:0]       p_eff, s_eff;
  logic [5:0]       ps;
  logic [DataW-1:0] unit, half, pow_p, pow_ps, y;
  logic [DataW-1:0] lo, hi, a_mag, b_mag, sum_mag;
  logic             a_neg, b_neg, bn, sum_neg, carry, pneg;
  logic [DataW:0]   sum;
  logic [2*DataW:0] div_lim;
  div_t             fx;
  logic             fin_neg, away;
  logic [DataW-1:0] fin_mag;
  status_e          fin_st;

  assign adv          = !out_valid_q || out_ready_i;
  assign item_ready_o = adv;
  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_q;

  // register values beyond the legal range are clamped
  always_comb begin
    p_eff = (precision_i == '0) ? 5'd1 :
            ((precision_i > 5'(MaxDigits)) ? 5'(MaxDigits) : precision_i);
    s_eff = (scale_i > 5'(MaxDigits)) ? 5'(MaxDigits) : scale_i;
    ps    = {1'b0, p_eff} + {1'b0, s_eff};
    unit  = pow10(s_eff);
    half  = unit >> 1;
    pow_p = pow10(p_eff);
    pow_ps = pow10(ps[4:0]);
  end

  // partial products of the 64 by 64 multiply
  always_comb begin
    y         = (item_i.op == OP_DIV) ? unit : item_i.b_mag;
    s1_d.item = item_i;
    s1_d.pp00 = item_i.a_mag[31:0]  * y[31:0];
    s1_d.pp01 = item_i.a_mag[31:0]  * y[63:32];
    s1_d.pp10 = item_i.a_mag[63:32] * y[31:0];
    s1_d.pp11 = item_i.a_mag[63:32] * y[63:32];
  end

  always_comb begin
    s2_d.item = s1_q.item;
    s2_d.prod = {s1_q.pp11, s1_q.pp00} + {32'b0, s1_q.pp01, 32'b0}
              + {32'b0, s1_q.pp10, 32'b0};
  end

  // range checks and divider operands
  always_comb begin
    a_neg = s2_q.item.a_neg;
    a_mag = s2_q.item.a_mag;
    b_neg = s2_q.item.b_neg;
    b_mag = s2_q.item.b_mag;
    lo    = s2_q.prod[DataW-1:0];
    hi    = s2_q.prod[2*DataW-1:DataW];
    bn    = (s2_q.item.op == OP_SUB) ? !b_neg : b_neg;
    sum   = {1'b0, a_mag} + {1'b0, b_mag};
    carry = 1'b0;
    if (a_neg == bn) begin
      sum_neg = a_neg;
      sum_mag = sum[DataW-1:0];
      carry   = sum[DataW];
    end else if (a_mag >= b_mag) begin
      sum_neg = a_neg;
      sum_mag = a_mag - b_mag;
    end else begin
      sum_neg = bn;
      sum_mag = b_mag - a_mag;
    end
    sum_neg = sum_neg && (sum_mag != '0);
    pneg    = (a_neg ^ b_neg) && (lo != '0);
    div_lim = {1'b0, s2_q.prod} + {65'b0, unit};

    s3_d.op      = s2_q.item.op;
    s3_d.st      = ST_OK;
    s3_d.res_neg = 1'b0;
    s3_d.res_mag = '0;
    s3_d.den     = unit;
    s3_d.rem     = '0;
    s3_d.nq      = a_mag;
    case (s2_q.item.op)
      OP_ADD, OP_SUB: begin
        s3_d.res_neg = sum_neg;
        s3_d.res_mag = sum_mag;
        if (carry || ((sum_neg == (s2_q.item.op == OP_SUB)) && sum_mag >= pow_p)) begin
          s3_d.st = ST_OVF;
        end
      end
      OP_MUL: begin
        if (hi != '0 || !fits(pneg, lo) || (ps <= 6'd19 && lo >= pow_ps)) begin
          s3_d.st = ST_OVF;
        end
        if (!pneg) begin
          s3_d.nq = lo + half;
        end else if (lo > half) begin
          s3_d.nq      = lo - half;
          s3_d.res_neg = 1'b1;
        end else begin
          s3_d.nq = half - lo;
        end
      end
      OP_DIV: begin
        if (b_mag == '0) begin
          s3_d.st = ST_DIV0;
        end else if (div_lim > {65'b0, (a_neg ? WMinMag : WMaxMag)}) begin
          s3_d.st = ST_OVF;
        end
        s3_d.nq      = a_neg ? (lo - half) : (lo + half);
        s3_d.res_neg = a_neg ^ b_neg;
        s3_d.den     = b_mag;
      end
      OP_MOD: begin
        if (b_mag == '0) begin
          s3_d.st = ST_DIV0;
        end
        s3_d.res_neg = a_neg;
        s3_d.den     = b_mag;
      end
      OP_NEG: begin
        s3_d.res_neg = !a_neg && (a_mag != '0);
        s3_d.res_mag = a_mag;
      end
      OP_ABS: begin
        s3_d.res_mag = a_mag;
      end
      OP_FLOOR, OP_CEIL: begin
        s3_d.res_neg = a_neg;
        s3_d.res_mag = a_mag;
      end
      default: begin
        s3_d.st = ST_OK;
      end
    endcase
  end

  // quotient or remainder selection, rounding to whole units, final range check
  always_comb begin
    fx      = dq_q[DivSteps-1];
    fin_neg = fx.res_neg;
    fin_mag = fx.res_mag;
    away    = (fx.op == OP_FLOOR) ? fx.res_neg : !fx.res_neg;
    case (fx.op)
      OP_MUL, OP_DIV: fin_mag = fx.nq;
      OP_MOD:         fin_mag = fx.rem;
      OP_FLOOR, OP_CEIL: begin
        if (fx.rem != '0) begin
          fin_mag = (fx.res_mag - fx.rem) + (away ? fx.den : 64'd0);
        end
      end
      default: fin_mag = fx.res_mag;
    endcase
    fin_neg = fin_neg && (fin_mag != '0);
    fin_st  = fx.st;
    if (fin_st == ST_OK && !fits(fin_neg, fin_mag)) begin
      fin_st = ST_OVF;
    end
    if (fin_st != ST_OK) begin
      fin_neg = 1'b0;
      fin_mag = '0;
    end
    out_d.value  = fin_neg ? (~fin_mag + 64'd1) : fin_mag;
    out_d.status = fin_st;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      dv_q        <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= item_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      dv_q        <= {dv_q[DivSteps-2:0], v3_q};
      out_valid_q <= dv_q[DivSteps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q     <= s1_d;
      s2_q     <= s2_d;
      s3_q     <= s3_d;
      dq_q[0]  <= div_step(s3_q);
      for (int i = 1; i < DivSteps; i++) begin
        dq_q[i] <= div_step(dq_q[i-1]);
      end
      out_q <= out_d;
    end
  end

endmodule

// ===== rtl/core/decimal_fixed_point_alu_core.sv =====
// top level of the scaled decimal arithmetic core: configuration registers,
// front, queue and back; depends on dfpa_pkg and the dfpa_* modules
`include "decimal_fixed_point_alu_core_assert.svh"
//
// channel   | direction | handshake               | payload
// ----------+-----------+-------------------------+--------------------------
// in        | input     | in_valid_i / in_ready_o | in_data_i (cmd, operands)
// out       | output    | out_valid_o/out_ready_i | out_data_o (value, status)
// cfg       | input     | cfg_we_i, no wait       | cfg_idx_i, cfg_wdata_i
//
// one transfer per cycle sustained while the output is not stalled; all commands
// pass the front register, the queue and the 64-stage radix-2 divider pipeline
// reset clears all valid bits and the queue; precision resets to 18, scale to 0
// a stalled output register holds the back pipeline, the 2-entry queue and
// front register then fill before in_ready_o drops
module decimal_fixed_point_alu_core #(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dfpa_pkg::dfpa_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dfpa_pkg::dfpa_out_t out_data_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [4:0]          cfg_wdata_i
);
  import dfpa_pkg::*;

  logic [CfgW-1:0]  precision_q, scale_q;
  logic             front_valid, q_push_ready, q_pop_valid, back_ready;
  dfpa_item_t       front_item, q_item;
  dfpa_front_stat_t fstat;
  logic             out_err;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      precision_q <= CfgW'(PrecisionRst);
      scale_q     <= CfgW'(ScaleRst);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_PRECISION: precision_q <= cfg_wdata_i;
        CFG_SCALE:     scale_q     <= cfg_wdata_i;
        default:       precision_q <= precision_q;
      endcase
    end
  end

  dfpa_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .item_valid_o (front_valid),
    .item_ready_i (q_push_ready),
    .item_o       (front_item)
  );

  dfpa_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (q_push_ready),
    .push_data_i  (front_item),
    .pop_valid_o  (q_pop_valid),
    .pop_ready_i  (back_ready),
    .pop_data_o   (q_item)
  );

  dfpa_back #(
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .precision_i  (precision_q),
    .scale_i      (scale_q),
    .item_valid_i (q_pop_valid),
    .item_ready_o (back_ready),
    .item_i       (q_item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

  assign fstat.pend = front_valid;
  assign fstat.full = !q_push_ready;
  assign out_err    = out_valid_o && (out_data_o.status != ST_OK);

  `DFPA_ASSERT_IMP(a_err_zero, out_err, out_data_o.value == '0, "error result with nonzero value")
  `DFPA_ASSERT_IMP(a_stall_cause, !in_ready_o, fstat.pend && fstat.full, "input stall with room")
  `DFPA_ASSERT_NXT(a_in_lands, in_valid_i && in_ready_o, fstat.pend, "input transfer lost")

endmodule
